@@ sv/idiv_pkg.sv @@
// Package for the signed/unsigned integer divider: widths, opcodes and transaction types.
// Used by every module of the divider; depends on nothing.
`default_nettype none

package idiv_pkg;

  localparam int unsigned DataWidth     = 64;
  localparam int unsigned MaxWidth      = 64;
  localparam int unsigned NarrowWidth   = (MaxWidth < 32) ? MaxWidth : 32;
  localparam int unsigned CntWidth      = $clog2(MaxWidth + 1);
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  localparam logic [DataWidth-1:0] NarrowMask =
    DataWidth'((65'd1 << NarrowWidth) - 65'd1);
  localparam logic [DataWidth-1:0] WideMask =
    DataWidth'((65'd1 << MaxWidth) - 65'd1);

  localparam logic [CntWidth-1:0] NarrowCount = CntWidth'(NarrowWidth);
  localparam logic [CntWidth-1:0] WideCount   = CntWidth'(MaxWidth);

  typedef enum logic [1:0] {
    OpUnsigned32 = 2'd0,
    OpSigned32   = 2'd1,
    OpUnsigned64 = 2'd2,
    OpSigned64   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
    logic                 divide_by_zero;
  } out_item_t;

  // Classified operation handed from the front end to the divider core.
  typedef struct packed {
    logic                 q_neg;     // negate quotient at the end
    logic                 r_neg;     // negate remainder at the end
    logic                 dvz;       // divisor zero within the mode width
    logic [CntWidth-1:0]  steps;     // quotient bits to produce
    logic [DataWidth-1:0] mask;      // mode width mask
    logic [DataWidth-1:0] num;       // left-aligned dividend magnitude, or masked dividend on dvz
    logic [DataWidth-1:0] den;       // divisor magnitude
  } work_t;

endpackage

`default_nettype wire

@@ sv/integer_divider_signed_unsigned_top.sv @@
// Top level of the signed/unsigned 32/64-bit integer divider.
// Depends on idiv_pkg, idiv_front, idiv_queue and idiv_core.
//
// Input channel: drive in_i and raise push; the transaction is taken on a clock edge
// with push high and full low. opcode selects unsigned/signed and 32/64-bit width.
// Result channel: while empty is low, out_o holds the oldest result; it is taken on a
// clock edge with pop high. Results come out in input order, one per input.
// The front end classifies the operands in the cycle of acceptance and writes them
// into a two-entry queue; the core takes one operation at a time from the queue.
// Timing: the core's shift-subtract loop produces one quotient bit per cycle; an
// operation passes through load, W steps and sign fix-up, W = 32 or 64. A zero
// divisor skips the loop and goes from load straight to fix-up. The core finishes
// one operation before it takes the next from the queue.
// When the receiver stalls, the finished result waits in the output register, the core
// waits in fix-up and the queue keeps taking input until full rises.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
`default_nettype none

module integer_divider_signed_unsigned_top (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var idiv_pkg::in_item_t  in_i,
  input  var logic                push,
  output var logic                full,
  output var idiv_pkg::out_item_t out_o,
  output var logic                empty,
  input  var logic                pop
);

  idiv_pkg::work_t work_in;
  idiv_pkg::work_t work_out;
  logic            work_empty;
  logic            work_pop;

  idiv_front u_front (
    .item_i (in_i),
    .work_o (work_in)
  );

  idiv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work_in),
    .full_o  (full),
    .pop_i   (work_pop),
    .data_o  (work_out),
    .empty_o (work_empty)
  );

  idiv_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work_out),
    .work_empty_i (work_empty),
    .work_pop_o   (work_pop),
    .out_o        (out_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

`default_nettype wire

@@ sv/idiv_front.sv @@
// Front end of the divider: masks operands to the mode width, detects a zero divisor,
// takes magnitudes and aligns the dividend. Depends on idiv_pkg.
`default_nettype none

module idiv_front (
  input  var idiv_pkg::in_item_t item_i,
  output var idiv_pkg::work_t    work_o
);

  logic                           is_signed;
  logic                           is_wide;
  logic [idiv_pkg::DataWidth-1:0] mask;
  logic [idiv_pkg::DataWidth-1:0] a;
  logic [idiv_pkg::DataWidth-1:0] b;
  logic                           a_neg;
  logic                           b_neg;
  logic [idiv_pkg::DataWidth-1:0] am;
  logic [idiv_pkg::DataWidth-1:0] bm;
  logic [idiv_pkg::DataWidth-1:0] am_aligned;

  always_comb begin
    is_signed = (item_i.opcode == idiv_pkg::OpSigned32) ||
                (item_i.opcode == idiv_pkg::OpSigned64);
    is_wide   = (item_i.opcode == idiv_pkg::OpUnsigned64) ||
                (item_i.opcode == idiv_pkg::OpSigned64);
    mask      = is_wide ? idiv_pkg::WideMask : idiv_pkg::NarrowMask;
    a         = item_i.dividend & mask;
    b         = item_i.divisor & mask;

    if (is_wide) begin
      a_neg = is_signed & a[idiv_pkg::MaxWidth-1];
      b_neg = is_signed & b[idiv_pkg::MaxWidth-1];
    end else begin
      a_neg = is_signed & a[idiv_pkg::NarrowWidth-1];
      b_neg = is_signed & b[idiv_pkg::NarrowWidth-1];
    end

    am = a_neg ? ((~a + 1'b1) & mask) : a;
    bm = b_neg ? ((~b + 1'b1) & mask) : b;

    // Put the dividend MSB at the top so the core always shifts out of bit DataWidth-1.
    if (is_wide) begin
      am_aligned = am << (idiv_pkg::DataWidth - idiv_pkg::MaxWidth);
    end else begin
      am_aligned = am << (idiv_pkg::DataWidth - idiv_pkg::NarrowWidth);
    end

    work_o.dvz   = (b == '0);
    work_o.q_neg = a_neg ^ b_neg;
    work_o.r_neg = a_neg;
    work_o.steps = is_wide ? idiv_pkg::WideCount : idiv_pkg::NarrowCount;
    work_o.mask  = mask;
    work_o.num   = work_o.dvz ? a : am_aligned;
    work_o.den   = bm;
  end

endmodule

`default_nettype wire

@@ sv/idiv_queue.sv @@
// Small queue of classified operations between the front end and the divider core.
// Depends on idiv_pkg.
`default_nettype none

module idiv_queue (
  input  var logic            clk_i,
  input  var logic            rst_ni,
  input  var logic            push_i,
  input  var idiv_pkg::work_t data_i,
  output var logic            full_o,
  input  var logic            pop_i,
  output var idiv_pkg::work_t data_o,
  output var logic            empty_o
);

  idiv_pkg::work_t                      mem_q [idiv_pkg::QueueDepth];
  logic [idiv_pkg::QueuePtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [idiv_pkg::QueuePtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [idiv_pkg::QueueCntWidth-1:0]   cnt_q, cnt_d;
  logic                                 do_push;
  logic                                 do_pop;

  assign full_o  = (cnt_q == idiv_pkg::QueueCntWidth'(idiv_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == idiv_pkg::QueuePtrWidth'(idiv_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == idiv_pkg::QueuePtrWidth'(idiv_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/idiv_core.sv @@
// Divider core: radix-2 restoring shift-subtract loop, sign fix-up and result register.
// Depends on idiv_pkg.
`default_nettype none

module idiv_core (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var idiv_pkg::work_t     work_i,
  input  var logic                work_empty_i,
  output var logic                work_pop_o,
  output var idiv_pkg::out_item_t out_o,
  output var logic                empty_o,
  input  var logic                pop_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFix
  } state_e;

  state_e                           state_q;
  logic [idiv_pkg::CntWidth-1:0]    cnt_q;
  logic [idiv_pkg::DataWidth-1:0]   num_q;
  logic [idiv_pkg::DataWidth-1:0]   den_q;
  logic [idiv_pkg::DataWidth-1:0]   rem_q;
  logic [idiv_pkg::DataWidth-1:0]   quo_q;
  logic [idiv_pkg::DataWidth-1:0]   mask_q;
  logic                             q_neg_q;
  logic                             r_neg_q;
  logic                             dvz_q;
  idiv_pkg::out_item_t              out_q;
  logic                             out_valid_q;

  logic [idiv_pkg::DataWidth:0]     rem_shift;
  logic [idiv_pkg::DataWidth+1:0]   diff;
  logic                             ge;
  logic [idiv_pkg::DataWidth-1:0]   quo_fix;
  logic [idiv_pkg::DataWidth-1:0]   rem_fix;
  logic                             out_free;

  // One restoring step: the shifted partial remainder is one bit wider, which stands in
  // for the carry out of the mode width.
  always_comb begin
    rem_shift = {rem_q, num_q[idiv_pkg::DataWidth-1]};
    diff      = {1'b0, rem_shift} - {2'b00, den_q};
    ge        = !diff[idiv_pkg::DataWidth+1];
    quo_fix   = q_neg_q ? ((~quo_q + 1'b1) & mask_q) : quo_q;
    rem_fix   = r_neg_q ? ((~rem_q + 1'b1) & mask_q) : rem_q;
  end

  assign out_free   = !out_valid_q || pop_i;
  assign work_pop_o = (state_q == StIdle) && !work_empty_i;
  assign out_o      = out_q;
  assign empty_o    = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      mask_q      <= '0;
      q_neg_q     <= 1'b0;
      r_neg_q     <= 1'b0;
      dvz_q       <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In fix-up a popped result is replaced by the new one below.
      if (out_valid_q && pop_i && (state_q != StFix)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!work_empty_i) begin
            mask_q <= work_i.mask;
            num_q  <= work_i.num;
            den_q  <= work_i.den;
            cnt_q  <= work_i.steps;
            dvz_q  <= work_i.dvz;
            if (work_i.dvz) begin
              quo_q   <= work_i.mask;
              rem_q   <= work_i.num;
              q_neg_q <= 1'b0;
              r_neg_q <= 1'b0;
              state_q <= StFix;
            end else begin
              quo_q   <= '0;
              rem_q   <= '0;
              q_neg_q <= work_i.q_neg;
              r_neg_q <= work_i.r_neg;
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          // Remainder stays below the divisor, so it always fits DataWidth bits.
          rem_q <= ge ? diff[idiv_pkg::DataWidth-1:0] : rem_shift[idiv_pkg::DataWidth-1:0];
          quo_q <= {quo_q[idiv_pkg::DataWidth-2:0], ge};
          num_q <= num_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == idiv_pkg::CntWidth'(1)) begin
            state_q <= StFix;
          end
        end
        StFix: begin
          if (out_free) begin
            out_q.quotient       <= quo_fix;
            out_q.remainder      <= rem_fix;
            out_q.divide_by_zero <= dvz_q;
            out_valid_q          <= 1'b1;
            state_q              <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_run_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (cnt_q != '0))
    else $error("divider loop running with zero steps left");

  a_last_step_to_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && cnt_q == idiv_pkg::CntWidth'(1)) |=> (state_q == StFix))
    else $error("divider loop did not finish after its last step");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_q)))
    else $error("waiting result overwritten or dropped");

  a_dvz_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.divide_by_zero) |->
      (out_q.quotient == idiv_pkg::NarrowMask || out_q.quotient == idiv_pkg::WideMask))
    else $error("zero-divisor result without all-ones quotient");

endmodule

`default_nettype wire
